/* rtl/owbm_pkg.sv */
// Shared types, codes, constants and the CRC step of the 1-Wire bus master.
package owbm_pkg;

  // Command codes as they arrive on the func field.
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_RESET     = 3'd1,
    CMD_WRITE_BIT = 3'd2,
    CMD_READ_BIT  = 3'd3,
    CMD_WRITE_BYTE = 3'd4,
    CMD_READ_BYTE = 3'd5,
    CMD_TRIPLET   = 3'd6,
    CMD_CLEAR_CRC = 3'd7
  } cmd_t;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RESET = 4'd1,
    PH_WBIT  = 4'd2,
    PH_RBIT  = 4'd3,
    PH_WBYTE = 4'd4,
    PH_RBYTE = 4'd5,
    PH_TRIPA = 4'd6,
    PH_TRIPB = 4'd7,
    PH_TRIPW = 4'd8
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_SMP  = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_ONE_LOW       = 3'd3,
    REG_ZERO_LOW      = 3'd4,
    REG_READ_SAMPLE   = 3'd5,
    REG_SLOT          = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  localparam int          PADDR_W     = 5;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [11:0] TICK_MAX    = 12'd4095;
  localparam logic [7:0]  CRC_POLY    = 8'h8C;

  localparam logic [9:0]  RESET_LOW_RST    = 10'd480;
  localparam logic [7:0]  PRESENCE_SMP_RST = 8'd70;
  localparam logic [9:0]  RESET_TAIL_RST   = 10'd410;
  localparam logic [5:0]  ONE_LOW_RST      = 6'd6;
  localparam logic [6:0]  ZERO_LOW_RST     = 7'd60;
  localparam logic [6:0]  READ_SAMPLE_RST  = 7'd15;
  localparam logic [6:0]  SLOT_RST         = 7'd70;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       search_bit;
    logic       search_conflict;
    logic       search_none;
    logic [7:0] crc_value;
    logic       crc_zero;
    logic       rejected;
  } result_t;

  // Classified item as it sits in the queue.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       line;
  } q_entry_t;

  // Slot timing points derived from the configuration registers.
  typedef struct packed {
    logic [9:0]  rst_low;
    logic [10:0] rst_sample;
    logic [11:0] rst_end;
    logic [5:0]  one_low;
    logic [6:0]  zero_low;
    logic [6:0]  rd_sample;
    logic [6:0]  rd_end;
    logic [6:0]  wr_end1;
    logic [6:0]  wr_end0;
  } timing_t;

  // One LSB-first step of the Dallas CRC-8.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic bit_in);
    logic [7:0] sh;
    sh = {1'b0, crc[7:1]};
    return (crc[0] ^ bit_in) ? (sh ^ CRC_POLY) : sh;
  endfunction

endpackage

/* rtl/onewire_bus_master_core.sv */
// Top level of the 1-Wire bus master: front end, queue, sequencer and registers.
//
// Usage: items arrive on cmd (func, data_byte, line_level) with cmd_valid and
// cmd_stall; a func of tick advances slot timing by one microsecond, other
// codes start a reset, bit, byte or search triplet sequence, or clear the CRC.
// Every accepted item yields exactly one transfer on res, with res_valid and
// res_stall: line drive, busy, done, presence, read data, search flags, CRC.
// An accepted item is held in a queue entry and then in the sequencer's output
// register before its result appears. Throughput: one item per cycle unless
// res_stall holds a waiting transfer; the sequencer updates its state for one
// item each cycle it pops, and the two-entry queue covers the pop decision.
// Stall: while res_stall holds a waiting transfer, the sequencer stops and
// the queue fills; cmd_stall rises once both queue entries are taken.
// Reset (rst, synchronous): phase idle, counters, CRC and flags cleared,
// queue emptied, timing registers back to their default microsecond values.
// Timing registers must be written over the APB port only while idle; the block does not enforce this.
module onewire_bus_master_core
  import owbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  item_t              cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output result_t            res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  timing_t  timing;
  q_entry_t entry;
  q_entry_t head;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  // Timing registers and the derived slot points.
  owbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .timing  (timing)
  );

  // Classify each item on its way in.
  owbm_front u_front (
    .item  (cmd),
    .entry (entry)
  );

  // Hold incoming items while the sequencer waits on the result side.
  assign cmd_stall = q_full;

  owbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_data  (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Advance the sequencer one item per free output slot.
  owbm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .timing     (timing),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

`ifndef SYNTH
  // The line is never pulled low once the sequence has ended.
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.busy_res || !res.drive_low))
    else $error("line driven while idle");

  // A rejected command cannot also finish a sequence.
  a_reject_not_done: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.done_res && res.rejected))
    else $error("rejected command reported done");

  // No answer on a triplet means nothing chosen and no conflict.
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.search_none) |-> (!res.search_bit && !res.search_conflict))
    else $error("inconsistent search flags");

  // The queue only fills up while the result side is held back.
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_stall) |-> $past(res_valid && res_stall))
    else $error("queue filled without output stall");
`endif

endmodule

/* rtl/owbm_regs.sv */
// Configuration registers behind the APB port and the derived slot timing points.
module owbm_regs
  import owbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output timing_t            timing
);

  logic [9:0] reset_low_time;
  logic [7:0] presence_sample_time;
  logic [9:0] reset_tail_time;
  logic [5:0] one_low_time;
  logic [6:0] zero_low_time;
  logic [6:0] read_sample_time;
  logic [6:0] slot_time;

  reg_idx_t idx;
  logic     wr_en;
  timing_t  timing_next;

  logic [9:0] rlt_eff;
  logic [7:0] pst_eff;
  logic [9:0] rtt_eff;
  logic [5:0] one_eff;
  logic [6:0] zero_eff;
  logic [6:0] rds_eff;
  logic [6:0] slot_eff;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time       <= RESET_LOW_RST;
      presence_sample_time <= PRESENCE_SMP_RST;
      reset_tail_time      <= RESET_TAIL_RST;
      one_low_time         <= ONE_LOW_RST;
      zero_low_time        <= ZERO_LOW_RST;
      read_sample_time     <= READ_SAMPLE_RST;
      slot_time            <= SLOT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_RESET_LOW:    reset_low_time       <= pwdata[9:0];
        REG_PRESENCE_SMP: presence_sample_time <= pwdata[7:0];
        REG_RESET_TAIL:   reset_tail_time      <= pwdata[9:0];
        REG_ONE_LOW:      one_low_time         <= pwdata[5:0];
        REG_ZERO_LOW:     zero_low_time        <= pwdata[6:0];
        REG_READ_SAMPLE:  read_sample_time     <= pwdata[6:0];
        REG_SLOT:         slot_time            <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RESET_LOW:    prdata = {22'd0, reset_low_time};
      REG_PRESENCE_SMP: prdata = {24'd0, presence_sample_time};
      REG_RESET_TAIL:   prdata = {22'd0, reset_tail_time};
      REG_ONE_LOW:      prdata = {26'd0, one_low_time};
      REG_ZERO_LOW:     prdata = {25'd0, zero_low_time};
      REG_READ_SAMPLE:  prdata = {25'd0, read_sample_time};
      REG_SLOT:         prdata = {25'd0, slot_time};
      default:          prdata = 32'd0;
    endcase
  end

  // A zero setting acts as one tick.
  always_comb begin
    rlt_eff  = (reset_low_time == '0)       ? 10'd1 : reset_low_time;
    pst_eff  = (presence_sample_time == '0) ? 8'd1  : presence_sample_time;
    rtt_eff  = (reset_tail_time == '0)      ? 10'd1 : reset_tail_time;
    one_eff  = (one_low_time == '0)         ? 6'd1  : one_low_time;
    zero_eff = (zero_low_time == '0)        ? 7'd1  : zero_low_time;
    rds_eff  = (read_sample_time == '0)     ? 7'd1  : read_sample_time;
    slot_eff = (slot_time == '0)            ? 7'd1  : slot_time;

    timing_next.rst_low    = rlt_eff;
    timing_next.rst_sample = {1'b0, rlt_eff} + {3'd0, pst_eff};
    timing_next.rst_end    = {1'b0, timing_next.rst_sample} + {2'd0, rtt_eff};
    timing_next.one_low    = one_eff;
    timing_next.zero_low   = zero_eff;
    timing_next.rd_sample  = rds_eff;
    timing_next.wr_end1    = (slot_eff > {1'b0, one_eff}) ? slot_eff : {1'b0, one_eff};
    timing_next.wr_end0    = (slot_eff > zero_eff) ? slot_eff : zero_eff;
    timing_next.rd_end     = (timing_next.wr_end1 > rds_eff) ? timing_next.wr_end1 : rds_eff;
  end

  // Registered once per cycle; settings must only change while the master is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    timing <= timing_next;
  end

endmodule

/* rtl/owbm_front.sv */
// Front end: classifies an incoming item into a queue entry.
module owbm_front
  import owbm_pkg::*;
(
  input  item_t    item,
  output q_entry_t entry
);

  always_comb begin
    entry.cmd  = cmd_t'(item.func);
    entry.data = item.data_byte;
    // Only ticks sample the line; drop it on commands.
    entry.line = (entry.cmd == CMD_TICK) ? item.line_level : 1'b0;
  end

endmodule

/* rtl/owbm_queue.sv */
// Short register queue between the front end and the sequencer.
module owbm_queue
  import owbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

/* rtl/owbm_engine.sv */
// Back end: slot sequencer, CRC and the registered result.
module owbm_engine
  import owbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  timing_t  timing,
  input  logic     head_valid,
  input  q_entry_t head,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_stall,
  output result_t  res
);

  phase_t      phase, phase_next;
  logic [11:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_data, shift_data_next;
  logic        presence_flag, presence_flag_next;
  logic [7:0]  crc_reg, crc_reg_next;
  logic [1:0]  triplet_reads, triplet_reads_next;
  logic        slot_bit, slot_bit_next;
  logic [2:0]  search_flags, search_flags_next;

  logic        done, rej, drive;
  logic        ta, tb;
  logic [11:0] t;
  logic [6:0]  wr_end;
  logic [6:0]  low_next;
  result_t     res_next;

  assign pop = head_valid && (!res_valid || !res_stall);

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    presence_flag_next = presence_flag;
    crc_reg_next       = crc_reg;
    triplet_reads_next = triplet_reads;
    slot_bit_next      = slot_bit;
    search_flags_next  = search_flags;
    done   = 1'b0;
    rej    = 1'b0;
    t      = (tick_count < TICK_MAX) ? tick_count + 12'd1 : tick_count;
    wr_end = slot_bit ? timing.wr_end1 : timing.wr_end0;
    ta     = triplet_reads[0];
    tb     = 1'b0;

    if (head.cmd != CMD_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else if (head.cmd == CMD_CLEAR_CRC) begin
        crc_reg_next = '0;
        done         = 1'b1;
      end else begin
        tick_count_next = '0;
        bit_index_next  = '0;
        phase_next      = phase_t'({1'b0, head.cmd});
        unique case (head.cmd)
          CMD_WRITE_BIT: slot_bit_next = head.data[0];
          CMD_WRITE_BYTE: begin
            slot_bit_next   = head.data[0];
            shift_data_next = {1'b0, head.data[7:1]};
          end
          CMD_READ_BYTE: shift_data_next = '0;
          CMD_TRIPLET: begin
            search_flags_next  = '0;
            triplet_reads_next = '0;
          end
          default: ;
        endcase
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = t;
      unique case (phase)
        PH_RESET: begin
          if (t == {1'b0, timing.rst_sample}) presence_flag_next = !head.line;
          if (t >= timing.rst_end) done = 1'b1;
        end
        PH_RBIT, PH_RBYTE, PH_TRIPA, PH_TRIPB: begin
          if (t == {5'd0, timing.rd_sample}) slot_bit_next = head.line;
          if (t >= {5'd0, timing.rd_end}) begin
            tick_count_next = '0;
            unique case (phase)
              PH_RBIT: begin
                shift_data_next = {7'd0, slot_bit_next};
                crc_reg_next    = crc8_feed(crc_reg, slot_bit_next);
                done            = 1'b1;
              end
              PH_RBYTE: begin
                shift_data_next[bit_index[2:0]] = shift_data[bit_index[2:0]] | slot_bit_next;
                crc_reg_next   = crc8_feed(crc_reg, slot_bit_next);
                bit_index_next = bit_index + 4'd1;
                done           = (bit_index_next >= 4'd8);
              end
              PH_TRIPA: begin
                triplet_reads_next = {1'b0, slot_bit_next};
                phase_next         = PH_TRIPB;
              end
              default: begin
                tb = slot_bit_next;
                triplet_reads_next = {tb, ta};
                if (ta && tb) begin
                  search_flags_next = 3'b100;
                  done              = 1'b1;
                end else begin
                  search_flags_next = {1'b0, !ta && !tb, ta};
                  crc_reg_next      = crc8_feed(crc_reg, ta);
                  slot_bit_next     = ta;
                  phase_next        = PH_TRIPW;
                end
              end
            endcase
          end
        end
        default: begin
          // Write slots: plain bit, byte, or the chosen triplet bit.
          if (t >= {5'd0, wr_end}) begin
            tick_count_next = '0;
            if (phase == PH_WBYTE) begin
              bit_index_next = bit_index + 4'd1;
              if (bit_index_next >= 4'd8) begin
                done = 1'b1;
              end else begin
                slot_bit_next   = shift_data[0];
                shift_data_next = {1'b0, shift_data[7:1]};
              end
            end else begin
              done = 1'b1;
            end
          end
        end
      endcase
      if (done) begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    end

    low_next = slot_bit_next ? {1'b0, timing.one_low} : timing.zero_low;
    unique case (phase_next)
      PH_IDLE:  drive = 1'b0;
      PH_RESET: drive = (tick_count_next < {2'd0, timing.rst_low});
      PH_RBIT, PH_RBYTE, PH_TRIPA, PH_TRIPB:
                drive = (tick_count_next < {6'd0, timing.one_low});
      default:  drive = (tick_count_next < {5'd0, low_next});
    endcase

    res_next.drive_low       = drive;
    res_next.busy_res        = (phase_next != PH_IDLE);
    res_next.done_res        = done;
    res_next.presence        = presence_flag_next;
    res_next.read_data       = shift_data_next;
    res_next.search_bit      = search_flags_next[0];
    res_next.search_conflict = search_flags_next[1];
    res_next.search_none     = search_flags_next[2];
    res_next.crc_value       = crc_reg_next;
    res_next.crc_zero        = (crc_reg_next == '0);
    res_next.rejected        = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_data    <= '0;
      presence_flag <= 1'b0;
      crc_reg       <= '0;
      triplet_reads <= '0;
      slot_bit      <= 1'b0;
      search_flags  <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_data    <= shift_data_next;
        presence_flag <= presence_flag_next;
        crc_reg       <= crc_reg_next;
        triplet_reads <= triplet_reads_next;
        slot_bit      <= slot_bit_next;
        search_flags  <= search_flags_next;
        res_valid     <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res <= res_next;
  end

endmodule
